[hw/rtl/etsc_pkg.sv]
`default_nettype none

package etsc_pkg;

    // Operating modes, one-hot inside the block.
    typedef enum logic [3:0] {
        MODE_SETTING    = 4'b0001,
        MODE_EXPOSING   = 4'b0010,
        MODE_HOME_RESET = 4'b0100,
        MODE_HOME_CLOSE = 4'b1000
    } mode_t;

    // Mode codes as they appear on the result word.
    localparam logic [1:0] MODE_CODE_SETTING    = 2'd0;
    localparam logic [1:0] MODE_CODE_EXPOSING   = 2'd1;
    localparam logic [1:0] MODE_CODE_HOME_RESET = 2'd2;
    localparam logic [1:0] MODE_CODE_HOME_CLOSE = 2'd3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_INITIAL_TIME     = 2'd0,
        CFG_MAX_TIME         = 2'd1,
        CFG_TICKS_PER_SECOND = 2'd2
    } cfg_idx_t;

    // Register values after reset.
    localparam int INITIAL_TIME_RST     = 600;
    localparam int MAX_TIME_RST         = 3600;
    localparam int TICKS_PER_SECOND_RST = 2273;

    // Input item kinds.
    localparam logic ACTION_TICK   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    // One input item.
    typedef struct packed {
        logic action;
        logic up_pressed;
        logic down_pressed;
        logic start_pressed;
        logic left_limit;
        logic right_limit;
    } item_t;

    // Outputs of one result word: the two-bit mode code and four single-bit flags.
    typedef struct packed {
        logic [1:0] mode_now;
        logic       motor_on;
        logic       motor_dir;
        logic       lamp_on;
        logic       tone_out;
    } flags_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        case (m)
            MODE_SETTING:    code = MODE_CODE_SETTING;
            MODE_EXPOSING:   code = MODE_CODE_EXPOSING;
            MODE_HOME_RESET: code = MODE_CODE_HOME_RESET;
            MODE_HOME_CLOSE: code = MODE_CODE_HOME_CLOSE;
            default:         code = MODE_CODE_HOME_RESET;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/etsc_cfg.sv]
`default_nettype none

module etsc_cfg #(
    parameter int TIME_BITS = 12,
    parameter int TICK_BITS = 16,
    parameter int CFG_BITS  = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [1:0]           wr_index,
    input  wire logic [CFG_BITS-1:0]  wr_data,
    output logic                      load_sel,
    output logic [TIME_BITS-1:0]      load_value,
    output logic [TIME_BITS-1:0]      max_time,
    output logic [TICK_BITS-1:0]      ticks_per_second
);

    logic [TIME_BITS-1:0] max_time_reg, max_time_next;
    logic [TICK_BITS-1:0] tps_reg, tps_next;
    etsc_pkg::cfg_idx_t   idx;

    assign idx        = etsc_pkg::cfg_idx_t'(wr_index);
    assign load_value = wr_data[TIME_BITS-1:0];

    always_comb
    begin
        max_time_next = max_time_reg;
        tps_next      = tps_reg;
        load_sel      = 1'b0;
        if (wr_en)
        begin
            case (idx)
                etsc_pkg::CFG_INITIAL_TIME:     load_sel = 1'b1;
                etsc_pkg::CFG_MAX_TIME:         max_time_next = wr_data[TIME_BITS-1:0];
                etsc_pkg::CFG_TICKS_PER_SECOND: tps_next = wr_data[TICK_BITS-1:0];
                default:                        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_time_reg <= TIME_BITS'(etsc_pkg::MAX_TIME_RST);
            tps_reg      <= TICK_BITS'(etsc_pkg::TICKS_PER_SECOND_RST);
        end
        else
        begin
            max_time_reg <= max_time_next;
            tps_reg      <= tps_next;
        end
    end

    assign max_time         = max_time_reg;
    assign ticks_per_second = tps_reg;

endmodule

`default_nettype wire

[hw/rtl/etsc_core.sv]
`default_nettype none

module etsc_core #(
    parameter int TIME_BITS = 12,
    parameter int TICK_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  wire etsc_pkg::item_t       item,
    input  wire logic                  load_sel,
    input  wire logic [TIME_BITS-1:0]  load_value,
    input  wire logic [TIME_BITS-1:0]  max_time,
    input  wire logic [TICK_BITS-1:0]  ticks_per_second,
    output etsc_pkg::flags_t           flags,
    output logic [TIME_BITS-1:0]       selected_time,
    output logic [TIME_BITS-1:0]       remaining_time
);

    etsc_pkg::mode_t      mode_reg, mode_next;
    logic [TIME_BITS-1:0] sel_reg, sel_next;
    logic [TIME_BITS-1:0] left_reg, left_next;
    logic [TICK_BITS-1:0] cnt_reg, cnt_next;
    logic                 start_now_reg, start_now_next;
    logic                 end_now_reg, end_now_next;
    logic                 motor_reg, motor_next;
    logic                 dir_reg, dir_next;
    logic                 lamp_reg, lamp_next;
    logic                 tone_reg, tone_next;

    logic                 start_edge;
    logic                 end_edge;
    logic [TIME_BITS:0]   sel_up;
    logic [TIME_BITS-1:0] sel_adj;
    logic [TICK_BITS-1:0] cnt_inc;

    assign start_edge = item.start_pressed & ~start_now_reg;
    assign end_edge   = (item.left_limit | item.right_limit) & ~end_now_reg;
    assign cnt_inc    = cnt_reg + 1'b1;

    // Up clamps to the maximum first, then down clamps to at least one.
    always_comb
    begin
        sel_up  = {1'b0, sel_reg};
        sel_adj = sel_reg;
        if (item.up_pressed)
        begin
            sel_up = {1'b0, sel_reg} + 1'b1;
            if (sel_up > {1'b0, max_time})
            begin
                sel_up = {1'b0, max_time};
            end
        end
        sel_adj = sel_up[TIME_BITS-1:0];
        if (item.down_pressed)
        begin
            if (sel_adj <= TIME_BITS'(1))
            begin
                sel_adj = TIME_BITS'(1);
            end
            else
            begin
                sel_adj = sel_adj - 1'b1;
            end
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        sel_next       = sel_reg;
        left_next      = left_reg;
        cnt_next       = cnt_reg;
        start_now_next = start_now_reg;
        end_now_next   = end_now_reg;
        motor_next     = motor_reg;
        dir_next       = dir_reg;
        lamp_next      = lamp_reg;
        tone_next      = tone_reg;

        if (item.action == etsc_pkg::ACTION_TICK)
        begin
            tone_next = ~tone_reg;
            if (mode_reg == etsc_pkg::MODE_EXPOSING)
            begin
                cnt_next = cnt_inc;
                if (cnt_inc == ticks_per_second)
                begin
                    cnt_next = '0;
                    if (left_reg != '0)
                    begin
                        left_next = left_reg - 1'b1;
                    end
                end
            end
        end
        else
        begin
            case (mode_reg)
                etsc_pkg::MODE_HOME_RESET,
                etsc_pkg::MODE_HOME_CLOSE:
                begin
                    if (!item.left_limit)
                    begin
                        motor_next = 1'b1;
                    end
                    else
                    begin
                        motor_next = 1'b0;
                        dir_next   = ~dir_reg;
                        mode_next  = etsc_pkg::MODE_SETTING;
                    end
                end
                etsc_pkg::MODE_SETTING:
                begin
                    start_now_next = item.start_pressed;
                    end_now_next   = item.left_limit | item.right_limit;
                    sel_next       = sel_adj;
                    if (start_edge)
                    begin
                        motor_next = 1'b1;
                        lamp_next  = 1'b1;
                        left_next  = sel_adj;
                        mode_next  = etsc_pkg::MODE_EXPOSING;
                    end
                end
                etsc_pkg::MODE_EXPOSING:
                begin
                    start_now_next = item.start_pressed;
                    end_now_next   = item.left_limit | item.right_limit;
                    if (end_edge)
                    begin
                        dir_next   = ~dir_reg;
                        motor_next = 1'b1;
                    end
                    if (start_edge || (end_edge && left_reg == '0))
                    begin
                        lamp_next  = 1'b0;
                        motor_next = 1'b0;
                        dir_next   = 1'b0;
                        mode_next  = etsc_pkg::MODE_HOME_CLOSE;
                    end
                end
                default:
                begin
                    mode_next = etsc_pkg::MODE_HOME_RESET;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= etsc_pkg::MODE_HOME_RESET;
            sel_reg       <= TIME_BITS'(etsc_pkg::INITIAL_TIME_RST);
            left_reg      <= '0;
            cnt_reg       <= '0;
            start_now_reg <= 1'b0;
            end_now_reg   <= 1'b0;
            motor_reg     <= 1'b0;
            dir_reg       <= 1'b0;
            lamp_reg      <= 1'b0;
            tone_reg      <= 1'b0;
        end
        else
        begin
            if (item_valid)
            begin
                mode_reg      <= mode_next;
                left_reg      <= left_next;
                cnt_reg       <= cnt_next;
                start_now_reg <= start_now_next;
                end_now_reg   <= end_now_next;
                motor_reg     <= motor_next;
                dir_reg       <= dir_next;
                lamp_reg      <= lamp_next;
                tone_reg      <= tone_next;
            end
            if (load_sel)
            begin
                sel_reg <= load_value;
            end
            else if (item_valid)
            begin
                sel_reg <= sel_next;
            end
        end
    end

    // The result word carries the state as it stands after this item.
    assign flags.mode_now  = etsc_pkg::mode_code(mode_next);
    assign flags.motor_on  = motor_next;
    assign flags.motor_dir = dir_next;
    assign flags.lamp_on   = lamp_next;
    assign flags.tone_out  = tone_next;
    assign selected_time   = sel_next;
    assign remaining_time  = left_next;

endmodule

`default_nettype wire

[hw/rtl/exposure_timer_shuttle_controller.sv]
// After its input word is accepted, a result word passes through the input
// register, then the result register.
// One word per cycle while the output side keeps up; one state update per item.
// Reset (rst_n low, asynchronous): the block starts in reset homing with the
// motor, lamp and tone off, 600 s selected, 3600 s maximum, 2273 ticks per s.
`default_nettype none

module exposure_timer_shuttle_controller #(
    parameter int TIME_BITS = 12,
    parameter int TICK_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // Input words.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    // Bits from 0 up: up_pressed, down_pressed, start_pressed, left_limit,
    // right_limit, then zero padding.
    input  wire logic [7:0] s_tdata,
    // Bit 0: action (0 timer tick, 1 control sample).
    input  wire logic       s_tuser,

    // Result words.
    output logic m_tvalid,
    input  wire logic m_tready,
    // Bits from 0 up: mode_now (2), motor_on, motor_dir, lamp_on, tone_out,
    // selected_time (TIME_BITS), remaining_time (TIME_BITS), zero padding.
    output logic [((6 + 2 * TIME_BITS + 7) / 8) * 8 - 1:0] m_tdata,

    // Configuration writes.
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [((TICK_BITS > TIME_BITS) ? TICK_BITS : TIME_BITS) - 1:0] cfg_data
);

    localparam int OUT_BITS = ((6 + 2 * TIME_BITS + 7) / 8) * 8;
    localparam int CFG_BITS = (TICK_BITS > TIME_BITS) ? TICK_BITS : TIME_BITS;
    localparam int PAD_BITS = OUT_BITS - 6 - 2 * TIME_BITS;

    // Input register: holds one word until the core has taken it.
    logic       in_valid_reg, in_valid_next;
    logic [4:0] in_data_reg;
    logic       in_user_reg;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0] out_data_reg;

    logic                 advance;
    etsc_pkg::item_t      item;
    etsc_pkg::flags_t     flags;
    logic [TIME_BITS-1:0] selected_time;
    logic [TIME_BITS-1:0] remaining_time;

    logic                 load_sel;
    logic [TIME_BITS-1:0] load_value;
    logic [TIME_BITS-1:0] max_time;
    logic [TICK_BITS-1:0] ticks_per_second;

    // The held word moves through the core whenever the result register is
    // free or being emptied in the same cycle, so a new word can enter every
    // cycle while the output side keeps up.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign item.action        = in_user_reg;
    assign item.up_pressed    = in_data_reg[0];
    assign item.down_pressed  = in_data_reg[1];
    assign item.start_pressed = in_data_reg[2];
    assign item.left_limit    = in_data_reg[3];
    assign item.right_limit   = in_data_reg[4];

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[4:0];
            in_user_reg <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= {{PAD_BITS{1'b0}}, remaining_time, selected_time,
                             flags.tone_out, flags.lamp_on, flags.motor_dir,
                             flags.motor_on, flags.mode_now};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    etsc_cfg #(
        .TIME_BITS (TIME_BITS),
        .TICK_BITS (TICK_BITS),
        .CFG_BITS  (CFG_BITS)
    ) u_cfg (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr_en            (cfg_valid && cfg_ready),
        .wr_index         (cfg_index),
        .wr_data          (cfg_data),
        .load_sel         (load_sel),
        .load_value       (load_value),
        .max_time         (max_time),
        .ticks_per_second (ticks_per_second)
    );

    etsc_core #(
        .TIME_BITS (TIME_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (advance),
        .item             (item),
        .load_sel         (load_sel),
        .load_value       (load_value),
        .max_time         (max_time),
        .ticks_per_second (ticks_per_second),
        .flags            (flags),
        .selected_time    (selected_time),
        .remaining_time   (remaining_time)
    );

endmodule

`default_nettype wire
